// ----- design/qsed_pkg.sv -----
// Shared types, codes and a helper function for the quoted string escape decoder.
package qsed_pkg;

	localparam int QUEUE_DEPTH_DEFAULT = 4;

	typedef enum logic [1:0] {
		OP_OPEN = 2'd0,
		OP_BYTE = 2'd1,
		OP_END  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_BODY = 2'd1,
		PH_ESC  = 2'd2,
		PH_HEX  = 2'd3
	} phase_t;

	localparam logic [1:0] KIND_BYTE  = 2'd0;
	localparam logic [1:0] KIND_CLOSE = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	localparam logic [2:0] ERR_UNTERMINATED = 3'd0;
	localparam logic [2:0] ERR_NL_LITERAL   = 3'd1;
	localparam logic [2:0] ERR_CTRL_LITERAL = 3'd2;
	localparam logic [2:0] ERR_OPEN_ESCAPE  = 3'd3;
	localparam logic [2:0] ERR_SHORT_HEX    = 3'd4;
	localparam logic [2:0] ERR_BAD_HEX      = 3'd5;
	localparam logic [2:0] ERR_UNKNOWN_ESC  = 3'd6;
	localparam logic [2:0] ERR_CTRL_BASIC   = 3'd7;

	localparam logic [7:0] UTF8_LEAD2  = 8'hC0;
	localparam logic [7:0] UTF8_LEAD3  = 8'hE0;
	localparam logic [7:0] UTF8_CONT   = 8'h80;
	localparam logic [5:0] UTF8_MASK   = 6'h3F;
	localparam logic [15:0] CP_TWO_MAX = 16'h0800;
	localparam logic [15:0] CP_ONE_MAX = 16'h0080;
	localparam logic [7:0] CTRL_LIMIT  = 8'h20;

	// One queue entry: all beats caused by one input item.
	typedef struct packed {
		logic [1:0] kind;
		logic [2:0] err;
		logic [1:0] count;
		logic [7:0] byte0;
		logic [7:0] byte1;
		logic [7:0] byte2;
	} job_t;

	typedef struct packed {
		logic valid;
		logic [3:0] value;
	} hex_t;

	function automatic hex_t hex_decode(input logic [7:0] c);
		hex_t h;
		h.valid = 1'b1;
		h.value = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			h.value = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			h.value = 4'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			h.value = 4'(c - 8'h37);
		end else begin
			h.valid = 1'b0;
		end
		return h;
	endfunction

endpackage

// ----- design/qsed_front.sv -----
// Front end: accepts input items, tracks string state and turns each item that yields output into a job.
module qsed_front import qsed_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [1:0] operation,
	input  logic [7:0] text_byte,
	input  logic       literal_mode,
	output logic       push,
	output job_t       job
);

	phase_t      phase_q, phase_d;
	logic        lit_q, lit_d;
	logic [1:0]  hex_q, hex_d;
	logic [15:0] cp_q, cp_d;
	logic [15:0] cp_next;
	hex_t        hv;
	logic        emit;

	assign hv      = hex_decode(text_byte);
	assign cp_next = {cp_q[11:0], hv.value};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			lit_q   <= 1'b0;
			hex_q   <= 2'd0;
			cp_q    <= 16'd0;
		end else if (take) begin
			phase_q <= phase_d;
			lit_q   <= lit_d;
			hex_q   <= hex_d;
			cp_q    <= cp_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		lit_d   = lit_q;
		hex_d   = hex_q;
		cp_d    = cp_q;
		emit    = 1'b0;
		job     = '0;
		job.count = 2'd1;
		case (op_t'(operation))
			OP_OPEN: begin
				phase_d = PH_BODY;
				lit_d   = literal_mode;
				hex_d   = 2'd0;
				cp_d    = 16'd0;
			end
			OP_BYTE: begin
				case (phase_q)
					PH_BODY: begin
						emit = 1'b1;
						if (lit_q) begin
							if (text_byte == 8'h27) begin
								job.kind = KIND_CLOSE;
								phase_d  = PH_IDLE;
							end else if (text_byte == 8'h0A) begin
								job.kind = KIND_ERROR;
								job.err  = ERR_NL_LITERAL;
								phase_d  = PH_IDLE;
							end else if (text_byte < CTRL_LIMIT) begin
								job.kind = KIND_ERROR;
								job.err  = ERR_CTRL_LITERAL;
								phase_d  = PH_IDLE;
							end else begin
								job.byte0 = text_byte;
							end
						end else begin
							if (text_byte == 8'h22) begin
								job.kind = KIND_CLOSE;
								phase_d  = PH_IDLE;
							end else if (text_byte == 8'h5C) begin
								emit    = 1'b0;
								phase_d = PH_ESC;
							end else if (text_byte != 8'h09 && text_byte != 8'h0A
									&& text_byte < CTRL_LIMIT) begin
								job.kind = KIND_ERROR;
								job.err  = ERR_CTRL_BASIC;
								phase_d  = PH_IDLE;
							end else begin
								job.byte0 = text_byte;
							end
						end
					end
					PH_ESC: begin
						emit    = 1'b1;
						phase_d = PH_BODY;
						case (text_byte)
							8'h6E: job.byte0 = 8'h0A;
							8'h74: job.byte0 = 8'h09;
							8'h72: job.byte0 = 8'h0D;
							8'h62: job.byte0 = 8'h08;
							8'h66: job.byte0 = 8'h0C;
							8'h22: job.byte0 = 8'h22;
							8'h5C: job.byte0 = 8'h5C;
							8'h75: begin
								emit    = 1'b0;
								phase_d = PH_HEX;
								hex_d   = 2'd0;
								cp_d    = 16'd0;
							end
							default: begin
								job.kind = KIND_ERROR;
								job.err  = ERR_UNKNOWN_ESC;
								phase_d  = PH_IDLE;
							end
						endcase
					end
					PH_HEX: begin
						if (!hv.valid) begin
							emit     = 1'b1;
							job.kind = KIND_ERROR;
							job.err  = ERR_BAD_HEX;
							phase_d  = PH_IDLE;
						end else begin
							cp_d = cp_next;
							if (hex_q != 2'd3) begin
								hex_d = hex_q + 2'd1;
							end else begin
								emit    = 1'b1;
								hex_d   = 2'd0;
								phase_d = PH_BODY;
								if (cp_next < CP_ONE_MAX) begin
									job.byte0 = cp_next[7:0];
								end else if (cp_next < CP_TWO_MAX) begin
									job.count = 2'd2;
									job.byte0 = UTF8_LEAD2 | {3'd0, cp_next[10:6]};
									job.byte1 = UTF8_CONT | {2'd0, cp_next[5:0] & UTF8_MASK};
								end else begin
									job.count = 2'd3;
									job.byte0 = UTF8_LEAD3 | {4'd0, cp_next[15:12]};
									job.byte1 = UTF8_CONT | {2'd0, cp_next[11:6] & UTF8_MASK};
									job.byte2 = UTF8_CONT | {2'd0, cp_next[5:0] & UTF8_MASK};
								end
							end
						end
					end
					default: begin
						emit = 1'b0;
					end
				endcase
			end
			OP_END: begin
				job.kind = KIND_ERROR;
				phase_d  = PH_IDLE;
				case (phase_q)
					PH_BODY: begin
						emit    = 1'b1;
						job.err = ERR_UNTERMINATED;
					end
					PH_ESC: begin
						emit    = 1'b1;
						job.err = ERR_OPEN_ESCAPE;
					end
					PH_HEX: begin
						emit    = 1'b1;
						job.err = ERR_SHORT_HEX;
					end
					default: begin
						emit = 1'b0;
					end
				endcase
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	assign push = take && emit;

endmodule

// ----- design/qsed_queue.sv -----
// Short job queue between the front end and the back end.
module qsed_queue import qsed_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t wr_job,
	input  logic pop,
	output job_t rd_job,
	output logic not_empty,
	output logic not_full
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push, do_pop;

	assign not_empty = count_q != CW'(0);
	assign not_full  = count_q != CW'(DEPTH);
	assign do_push   = push && not_full;
	assign do_pop    = pop && not_empty;
	assign rd_job    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

// ----- design/qsed_back.sv -----
// Back end: splits each job into result beats and holds them in the output register.
module qsed_back import qsed_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  job_t       job,
	input  logic       job_valid,
	output logic       pop,
	output logic       result_valid,
	input  logic       result_ready,
	output logic [1:0] result_kind,
	output logic [7:0] decoded_byte,
	output logic [2:0] error_code,
	output logic       last_of_run
);

	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [1:0] kind_q;
	logic [7:0] byte_q;
	logic [2:0] err_q;
	logic       last_q;
	logic       load;
	logic       is_last;
	logic [7:0] sel_byte;

	assign load    = job_valid && (!out_valid_q || result_ready);
	assign is_last = idx_q == (job.count - 2'd1);
	assign pop     = load && is_last;

	always_comb begin
		case (idx_q)
			2'd0:    sel_byte = job.byte0;
			2'd1:    sel_byte = job.byte1;
			2'd2:    sel_byte = job.byte2;
			default: sel_byte = 8'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= job.kind;
			byte_q <= sel_byte;
			err_q  <= job.err;
			last_q <= is_last;
		end
	end

	assign result_valid = out_valid_q;
	assign result_kind  = kind_q;
	assign decoded_byte = byte_q;
	assign error_code   = err_q;
	assign last_of_run  = last_q;

endmodule

// ----- design/quoted_string_escape_decoder.sv -----
// Top level of the quoted string escape decoder: front end, job queue and back end.
//
//   Channel   Handshake                  Beat contents
//   item      item_valid / item_ready    operation, text_byte, literal_mode
//   result    result_valid / result_ready result_kind, decoded_byte, error_code, last_of_run
//
// An item is classified combinationally and its job is written into the job queue at the edge
// that accepts it; the job's first result beat is then loaded into the output register.
// One item per cycle is accepted while the job queue is not full; a \u escape that expands to
// two or three bytes occupies the output for one beat per byte while the queue keeps taking items.
// The reset clears string state, queue pointers and the output valid flag.
// item_ready drops only when the job queue is full.
module quoted_string_escape_decoder import qsed_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  logic [1:0] operation,
	input  logic [7:0] text_byte,
	input  logic       literal_mode,
	output logic       result_valid,
	input  logic       result_ready,
	output logic [1:0] result_kind,
	output logic [7:0] decoded_byte,
	output logic [2:0] error_code,
	output logic       last_of_run
);

	logic take;
	logic push;
	job_t front_job;
	job_t head_job;
	logic head_valid;
	logic not_full;
	logic pop;

	assign item_ready = not_full;
	assign take       = item_valid && not_full;

	qsed_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.operation    (operation),
		.text_byte    (text_byte),
		.literal_mode (literal_mode),
		.push         (push),
		.job          (front_job)
	);

	qsed_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_job    (front_job),
		.pop       (pop),
		.rd_job    (head_job),
		.not_empty (head_valid),
		.not_full  (not_full)
	);

	qsed_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job          (head_job),
		.job_valid    (head_valid),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_kind  (result_kind),
		.decoded_byte (decoded_byte),
		.error_code   (error_code),
		.last_of_run  (last_of_run)
	);

endmodule
